// File: hw/rtl/pvp_pkg.sv
// pvp_pkg: types and constants shared by the perspective viewport projection block
// no dependencies
`default_nettype none
package pvp_pkg;

  localparam int COEF_W   = 32;
  localparam int CLIP_W   = 58;
  localparam int MAG_W    = 57;
  localparam int SIZE_W   = 16;
  localparam int K_W      = 23;
  localparam int NUM_W    = 80;
  localparam int QB       = 35;
  localparam int DIV_LAT  = QB + 1;
  localparam int PIX_W    = 40;
  localparam int NUM_ROWS = 6;
  localparam logic [CLIP_W-1:0] W_MIN_Q16 = CLIP_W'(656);

  typedef enum logic [3:0] {
    REG_ROW_X0  = 4'd0,
    REG_ROW_X1  = 4'd1,
    REG_ROW_Y0  = 4'd2,
    REG_ROW_Y1  = 4'd3,
    REG_ROW_W0  = 4'd4,
    REG_ROW_W1  = 4'd5,
    REG_WIDTH   = 4'd6,
    REG_HEIGHT  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
  } out_item_t;

  typedef struct packed {
    logic                     vis;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] cw;
  } clip_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [NUM_ROWS-1:0][63:0] matrix_t;

endpackage
`default_nettype wire

// File: hw/rtl/pvp_front.sv
// pvp_front: accepts points, forms clip x, y, w and classifies visibility
// depends on pvp_pkg
`default_nettype none
module pvp_front
  import pvp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  input  wire matrix_t    mat,
  input  wire q_stat_t    q_stat,
  output logic            q_push,
  output clip_item_t      q_wdata
);

  logic                     f1_valid_r;
  logic                     f2_valid_r;
  logic signed [63:0]       prod_r [3][3];
  logic signed [CLIP_W-1:0] clip_r [3];
  logic                     adv;
  logic signed [31:0]       pt [3];

  function automatic logic signed [31:0] coef(matrix_t m, int row, int i);
    logic [63:0] r;
    r = m[row * 2 + i / 2];
    return (i % 2 == 1) ? $signed(r[63:32]) : $signed(r[31:0]);
  endfunction

  assign adv      = !f2_valid_r || !q_stat.full;
  assign in_ready = adv;
  assign q_push   = f2_valid_r && !q_stat.full;
  assign pt[0]    = in_data.point_x;
  assign pt[1]    = in_data.point_y;
  assign pt[2]    = in_data.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  // products of each row with the point
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[r][i] <= coef(mat, r, i) * pt[i];
        end
      end
    end
  end

  // floored sums plus constant coefficient
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        clip_r[r] <= CLIP_W'(coef(mat, r, 3))
                   + CLIP_W'(prod_r[r][0] >>> 8)
                   + CLIP_W'(prod_r[r][1] >>> 8)
                   + CLIP_W'(prod_r[r][2] >>> 8);
      end
    end
  end

  always_comb begin
    q_wdata.cx  = clip_r[0];
    q_wdata.cy  = clip_r[1];
    q_wdata.cw  = clip_r[2];
    q_wdata.vis = (clip_r[2] >= $signed(W_MIN_Q16));
  end

endmodule
`default_nettype wire

// File: hw/rtl/pvp_queue.sv
// pvp_queue: short fifo between the front and the back
// depends on pvp_pkg
`default_nettype none
module pvp_queue
  import pvp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire clip_item_t wdata,
  input  wire logic       pop,
  output clip_item_t      rdata,
  output q_stat_t         stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clip_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pvp_div.sv
// pvp_div: pipelined restoring divider, one quotient bit per stage, capped at 2^34
// depends on pvp_pkg
`default_nettype none
module pvp_div
  import pvp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [MAG_W-1:0] den,
  output logic [QB-1:0]         term
);

  logic             cap_r [DIV_LAT];
  logic [MAG_W-1:0] rem_r [DIV_LAT];
  logic [MAG_W-1:0] den_r [DIV_LAT];
  logic [QB-1:0]    nb_r  [DIV_LAT];
  logic [QB-1:0]    q_r   [DIV_LAT];
  logic             cap_in;

  assign cap_in = (NUM_W'(num[NUM_W-1:QB]) >= NUM_W'(den));

  always_ff @(posedge clk) begin
    if (en) begin
      cap_r[0] <= cap_in;
      rem_r[0] <= cap_in ? '0 : MAG_W'(num[NUM_W-1:QB]);
      den_r[0] <= den;
      nb_r[0]  <= num[QB-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
    logic [MAG_W:0] shifted;
    logic           ge;
    assign shifted = {rem_r[s-1], nb_r[s-1][QB-1]};
    assign ge      = (shifted >= {1'b0, den_r[s-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        cap_r[s] <= cap_r[s-1];
        den_r[s] <= den_r[s-1];
        nb_r[s]  <= {nb_r[s-1][QB-2:0], 1'b0};
        q_r[s]   <= {q_r[s-1][QB-2:0], ge};
        rem_r[s] <= ge ? MAG_W'(shifted - {1'b0, den_r[s-1]}) : MAG_W'(shifted);
      end
    end
  end

  always_comb begin
    if (cap_r[DIV_LAT-1] || q_r[DIV_LAT-1][QB-1]) begin
      term = QB'(1) << (QB - 1);
    end else begin
      term = q_r[DIV_LAT-1];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pvp_back.sv
// pvp_back: scales clip x and y, divides by w and maps to saturated pixels
// depends on pvp_pkg and pvp_div
`default_nettype none
module pvp_back
  import pvp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_stat_t           q_stat,
  input  wire clip_item_t        q_rdata,
  output logic                   q_pop,
  input  wire logic [SIZE_W-1:0] screen_w,
  input  wire logic [SIZE_W-1:0] screen_h,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data
);

  localparam int SIDE = 3 + DIV_LAT;

  logic             en;
  logic             vld_r [SIDE];
  logic             vis_r [SIDE];
  logic             sx_r  [SIDE];
  logic             sy_r  [SIDE];
  logic [MAG_W-1:0] magx_r, magy_r;
  logic [MAG_W-1:0] den0_r, den1_r, den2_r;
  logic [47:0]      phx_r, phy_r;
  logic [54:0]      plx_r, ply_r;
  logic [NUM_W-1:0] numx_r, numy_r;
  logic [K_W-1:0]   kx, ky;
  logic [QB-1:0]    termx, termy;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic signed [PIX_W-1:0] tx, ty, px, py;

  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign kx        = {screen_w, 7'b0};
  assign ky        = {screen_h, 7'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_stat.empty;
      for (int i = 1; i < SIDE; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[SIDE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0] <= q_rdata.vis;
      sx_r[0]  <= q_rdata.cx[CLIP_W-1];
      sy_r[0]  <= q_rdata.cy[CLIP_W-1];
      for (int i = 1; i < SIDE; i++) begin
        vis_r[i] <= vis_r[i-1];
        sx_r[i]  <= sx_r[i-1];
        sy_r[i]  <= sy_r[i-1];
      end
      // magnitudes
      magx_r <= MAG_W'(q_rdata.cx[CLIP_W-1] ? -q_rdata.cx : q_rdata.cx);
      magy_r <= MAG_W'(q_rdata.cy[CLIP_W-1] ? -q_rdata.cy : q_rdata.cy);
      den0_r <= MAG_W'(q_rdata.cw);
      // partial products
      phx_r  <= 48'(magx_r[MAG_W-1:32]) * 48'(kx);
      plx_r  <= 55'(magx_r[31:0]) * 55'(kx);
      phy_r  <= 48'(magy_r[MAG_W-1:32]) * 48'(ky);
      ply_r  <= 55'(magy_r[31:0]) * 55'(ky);
      den1_r <= den0_r;
      // full dividends
      numx_r <= (NUM_W'(phx_r) << 32) + NUM_W'(plx_r);
      numy_r <= (NUM_W'(phy_r) << 32) + NUM_W'(ply_r);
      den2_r <= den1_r;
    end
  end

  pvp_div u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (numx_r),
    .den  (den2_r),
    .term (termx)
  );

  pvp_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (numy_r),
    .den  (den2_r),
    .term (termy)
  );

  function automatic logic signed [31:0] sat32(logic signed [PIX_W-1:0] v);
    if (v > $signed(PIX_W'(32'h7fff_ffff))) return 32'sh7fff_ffff;
    if (v < -$signed(PIX_W'(33'h1_0000_0000) >>> 1)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  always_comb begin
    tx = sx_r[SIDE-1] ? -$signed(PIX_W'(termx)) : $signed(PIX_W'(termx));
    ty = sy_r[SIDE-1] ? -$signed(PIX_W'(termy)) : $signed(PIX_W'(termy));
    px = $signed(PIX_W'({screen_w, 7'b0})) + $signed(PIX_W'(128)) + tx;
    py = $signed(PIX_W'({screen_h, 7'b0})) - $signed(PIX_W'(128)) - ty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.visible <= vis_r[SIDE-1];
      out_data_r.pixel_x <= vis_r[SIDE-1] ? sat32(px) : '0;
      out_data_r.pixel_y <= vis_r[SIDE-1] ? sat32(py) : '0;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/perspective_viewport_projection.sv
// perspective_viewport_projection: top level, configuration registers and wiring
// depends on pvp_pkg, pvp_front, pvp_queue, pvp_back
`default_nettype none
// Projects one world point per clock: once the pipeline is full and the output is not
// stalled, a new point is taken and one result leaves every cycle. A stalled output
// freezes the back while the front keeps filling the queue. The front registers products,
// then sums; the back registers magnitudes, partial products and full dividends, runs the
// bit-per-stage dividers and registers the output. Configuration writes are always taken.
module perspective_viewport_projection
  import pvp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  matrix_t           mat_r;
  logic [SIZE_W-1:0] width_r, height_r;
  q_stat_t           q_stat;
  logic              q_push, q_pop;
  clip_item_t        q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r    <= '0;
      width_r  <= SIZE_W'(1920);
      height_r <= SIZE_W'(1080);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_X0: mat_r[0] <= cfg_data;
        REG_ROW_X1: mat_r[1] <= cfg_data;
        REG_ROW_Y0: mat_r[2] <= cfg_data;
        REG_ROW_Y1: mat_r[3] <= cfg_data;
        REG_ROW_W0: mat_r[4] <= cfg_data;
        REG_ROW_W1: mat_r[5] <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  pvp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .mat      (mat_r),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  pvp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pvp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .screen_w  (width_r),
    .screen_h  (height_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("queue pop while empty");
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |-> out_data.pixel_x == 0 && out_data.pixel_y == 0)
    else $error("hidden point with nonzero pixels");
`endif

endmodule
`default_nettype wire
